>>> src/txc_pkg.sv
// ----------------------------------------------------------------------------
// txc_pkg: shared types and constants of the text console writer
// Request and response payloads, operation codes, sequencer states, and the
// character codes the cursor logic reacts to.
// ----------------------------------------------------------------------------
`default_nettype none

package txc_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam logic [7:0]  CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0]  CHAR_TAB       = 8'h09;
   localparam logic [7:0]  CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0]  CHAR_RETURN    = 8'h0D;
   localparam logic [7:0]  CHAR_BLANK     = 8'h20;

   localparam logic [15:0] RESET_CELL     = 16'h0220;
   localparam logic [3:0]  FG_RESET       = 4'd2;
   localparam logic [3:0]  BG_RESET       = 4'd0;

   localparam logic        CSR_FOREGROUND = 1'b0;
   localparam logic        CSR_BACKGROUND = 1'b1;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_SCROLL,
      S_FLUSH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_word;
      logic [10:0] cursor_index;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_line;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/txc_ram.sv
// ----------------------------------------------------------------------------
// txc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module txc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: character cell console with cursor, wrap and scroll
// A put, read or no-op goes through the result state to the result strobe.
// A clear blanks every cell and a put that scrolls moves each row up a row,
// both through the single write port of the cell store, one cell per cycle.
// Busy drops in the strobe cycle, so a new operation can start then.
// After reset the store is swept to blanks, busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txc_pkg::ROWS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire txc_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output txc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [3:0]       csr_wdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(COLUMNS);
   localparam int YW    = $clog2(ROWS);

   txc_pkg::state_type state_ff, state_in;

   logic [XW-1:0]    cursor_x_ff, cursor_x_in;
   logic [YW-1:0]    cursor_y_ff, cursor_y_in;
   logic [3:0]       fg_ff, bg_ff;
   logic [AW-1:0]    cnt_ff, cnt_in;
   logic             is_read_ff, is_read_in;
   logic             in_range_ff, in_range_in;
   logic             wr_pend_ff;
   logic [AW-1:0]    wr_addr_ff;
   logic             wr_copy_ff;
   logic             rsp_strobe_ff, rsp_strobe_in;
   txc_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             cnt_last;
   logic [15:0]      blank;
   logic [AW-1:0]    cursor_pos;
   logic             printable;

   logic [XW:0]      x_step;
   logic [YW:0]      y_step;
   logic             scroll;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [15:0]      mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [15:0]      mem_rdata;

   assign busy       = (state_ff != txc_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign cnt_last   = (cnt_ff == AW'(CELLS - 1));
   assign blank      = {bg_ff, fg_ff, txc_pkg::CHAR_BLANK};
   assign cursor_pos = AW'(AW'(cursor_y_ff) * AW'(COLUMNS) + AW'(cursor_x_ff));
   assign printable  = (req_data.char_code >= txc_pkg::CHAR_BLANK) && !req_data.char_code[7];

   // cursor movement for one character, then wrap and scroll check
   always_comb begin
      x_step = {1'b0, cursor_x_ff};
      y_step = {1'b0, cursor_y_ff};
      case (req_data.char_code)
         txc_pkg::CHAR_BACKSPACE: begin
            if (cursor_x_ff != '0) begin
               x_step = x_step - 1'b1;
            end
         end
         txc_pkg::CHAR_TAB: begin
            x_step = (x_step + (XW+1)'(8)) & ~(XW+1)'(7);
         end
         txc_pkg::CHAR_RETURN: begin
            x_step = '0;
         end
         txc_pkg::CHAR_NEWLINE: begin
            x_step = '0;
            y_step = y_step + 1'b1;
         end
         default: begin
            if (printable) begin
               x_step = x_step + 1'b1;
            end
         end
      endcase
      if (x_step >= (XW+1)'(COLUMNS)) begin
         x_step = '0;
         y_step = y_step + 1'b1;
      end
      scroll = (y_step >= (YW+1)'(ROWS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         txc_pkg::S_INIT: begin
            if (cnt_last) begin
               state_in = txc_pkg::S_IDLE;
            end
         end
         txc_pkg::S_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  txc_pkg::OP_PUT:   state_in = scroll ? txc_pkg::S_SCROLL : txc_pkg::S_DONE;
                  txc_pkg::OP_CLEAR: state_in = txc_pkg::S_CLEAR;
                  default:           state_in = txc_pkg::S_DONE;
               endcase
            end
         end
         txc_pkg::S_CLEAR: begin
            if (cnt_last) begin
               state_in = txc_pkg::S_DONE;
            end
         end
         txc_pkg::S_SCROLL: begin
            if (cnt_last) begin
               state_in = txc_pkg::S_FLUSH;
            end
         end
         txc_pkg::S_FLUSH: begin
            state_in = txc_pkg::S_DONE;
         end
         txc_pkg::S_DONE: begin
            state_in = txc_pkg::S_IDLE;
         end
         default: begin
            state_in = txc_pkg::S_IDLE;
         end
      endcase
   end

   // store port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = blank;
      mem_raddr = AW'(req_data.cell_index);
      case (state_ff)
         txc_pkg::S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = txc_pkg::RESET_CELL;
         end
         txc_pkg::S_IDLE: begin
            if (accept && req_data.operation == txc_pkg::OP_PUT && printable) begin
               mem_we    = 1'b1;
               mem_waddr = cursor_pos;
               mem_wdata = {bg_ff, fg_ff, req_data.char_code};
            end
         end
         txc_pkg::S_CLEAR: begin
            mem_we = 1'b1;
         end
         txc_pkg::S_SCROLL, txc_pkg::S_FLUSH: begin
            // read runs one row ahead, the write of each cell follows in the cycle after its read
            mem_raddr = AW'({1'b0, cnt_ff} + (AW+1)'(COLUMNS));
            mem_we    = wr_pend_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = wr_copy_ff ? mem_rdata : blank;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      is_read_in    = is_read_ff;
      in_range_in   = in_range_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cnt_in        = cnt_ff;
      if (state_ff == txc_pkg::S_INIT || state_ff == txc_pkg::S_CLEAR ||
          state_ff == txc_pkg::S_SCROLL) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end
      if (accept) begin
         is_read_in  = (req_data.operation == txc_pkg::OP_READ);
         in_range_in = (32'(req_data.cell_index) < 32'(CELLS));
         case (req_data.operation)
            txc_pkg::OP_PUT: begin
               cursor_x_in = XW'(x_step);
               cursor_y_in = scroll ? YW'(ROWS - 1) : YW'(y_step);
            end
            txc_pkg::OP_CLEAR: begin
               cursor_x_in = '0;
               cursor_y_in = '0;
            end
            default: begin
               cursor_x_in = cursor_x_ff;
            end
         endcase
      end
      if (state_ff == txc_pkg::S_DONE) begin
         rsp_strobe_in        = 1'b1;
         rsp_in.cell_word     = (is_read_ff && in_range_ff) ? mem_rdata : 16'h0000;
         rsp_in.cursor_index  = 11'(cursor_pos);
         rsp_in.cursor_column = 7'(cursor_x_ff);
         rsp_in.cursor_line   = 5'(cursor_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= txc_pkg::S_INIT;
         cnt_ff        <= '0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         fg_ff         <= txc_pkg::FG_RESET;
         bg_ff         <= txc_pkg::BG_RESET;
         is_read_ff    <= 1'b0;
         in_range_ff   <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         is_read_ff    <= is_read_in;
         in_range_ff   <= in_range_in;
         wr_pend_ff    <= (state_ff == txc_pkg::S_SCROLL);
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               txc_pkg::CSR_FOREGROUND: fg_ff <= csr_wdata;
               txc_pkg::CSR_BACKGROUND: bg_ff <= csr_wdata;
               default:                 fg_ff <= fg_ff;
            endcase
         end
      end
   end

   // scroll write pipeline payload and response register
   always_ff @(posedge clock) begin
      wr_addr_ff <= cnt_ff;
      wr_copy_ff <= (32'(cnt_ff) < 32'(CELLS - COLUMNS));
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   txc_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // a transfer only comes out of the result state
   a_strobe_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == txc_pkg::S_DONE))
      else $error("result strobe without result state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting an operation");

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      (32'(cursor_x_ff) < 32'(COLUMNS)) && (32'(cursor_y_ff) < 32'(ROWS)))
      else $error("cursor outside the screen");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !is_read_ff |-> rsp_data.cell_word == 16'h0000)
      else $error("non-read transfer carries a cell word");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == txc_pkg::S_IDLE) && !accept |-> !mem_we)
      else $error("store written while idle");

endmodule

`default_nettype wire
